FILE: sv/wsd_pkg.sv
package wsd_pkg;

    localparam int CONTROL_MAX = 125;
    localparam int HEADER_MAX  = 14;
    localparam int BANK_DEPTH  = 128;
    localparam int BANK_AW     = $clog2(BANK_DEPTH);
    localparam int RAM_DEPTH   = 2 * BANK_DEPTH;
    localparam int RAM_AW      = $clog2(RAM_DEPTH);

    localparam logic [1:0] ST_OPEN   = 2'd0;
    localparam logic [1:0] ST_CLOSED = 2'd1;
    localparam logic [1:0] ST_ERROR  = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_PROTOCOL = 2'd1;
    localparam logic [1:0] STATUS_CLOSED   = 2'd2;
    localparam logic [1:0] STATUS_NO_REPLY = 2'd3;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    localparam logic OPERATION_RECEIVE = 1'b0;
    localparam logic OPERATION_DRAIN   = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
        logic       chunk_end;
    } item_t;

    // Number of extended length bytes for a 7-bit length code.
    function automatic logic [3:0] ext_bytes(input logic [6:0] code);
        logic [3:0] n;
        begin
            n = 4'd0;
            if (code == 7'd126) n = 4'd2;
            if (code == 7'd127) n = 4'd8;
            return n;
        end
    endfunction

endpackage

FILE: sv/wsd_ram.sv
module wsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/wsd_front.sv
module wsd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  wsd_pkg::item_t     in_item,
    output logic               q_valid,
    input  logic               q_ready,
    output wsd_pkg::item_t     q_item
);

    // Two-entry queue that decouples the link side from the parser.
    wsd_pkg::item_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           push, pop;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3) else $error("queue count out of range");
    a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2 && !pop) |=> count_reg == 2'd2)
        else $error("queue lost an entry");
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers out of step");
`endif

endmodule

FILE: sv/wsd_back.sv
module wsd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic           cfg_wdata,
    input  logic           q_valid,
    output logic           q_ready,
    input  wsd_pkg::item_t q_item,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [1:0]     status,
    output logic           need_more,
    output logic           data_valid,
    output logic [7:0]     data_out,
    output logic           frame_end,
    output logic           message_end,
    output logic           reply_valid,
    output logic [7:0]     reply_byte,
    output logic           reply_last
);

    // Parser state
    logic        expect_masked_reg;
    logic [1:0]  stage_reg, stage_next;
    logic [3:0]  hcount_reg, hcount_next;
    logic [3:0]  hneed_reg, hneed_next;
    logic [7:0]  first_reg, first_next;
    logic [6:0]  lcode_reg, lcode_next;
    logic [63:0] ext_reg, ext_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        ctrl_reg, ctrl_next;
    logic        msg_open_reg, msg_open_next;
    logic [63:0] remain_reg, remain_next;
    logic [7:0]  key_reg [4];
    logic [7:0]  key_next [4];
    logic [1:0]  kidx_reg, kidx_next;
    logic [6:0]  ccount_reg, ccount_next;
    logic        ctrl_bank_reg, ctrl_bank_next;
    logic        reply_bank_reg, reply_bank_next;
    logic [7:0]  rlen_reg, rlen_next;
    logic [7:0]  rtaken_reg, rtaken_next;
    logic [7:0]  rhdr_reg, rhdr_next;

    // Result register
    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic        need_more_reg, data_valid_reg, frame_end_reg, message_end_reg;
    logic [7:0]  data_out_reg;
    logic        reply_valid_reg, reply_last_reg, reply_ram_reg;
    logic [7:0]  reply_byte_reg;

    logic [1:0]  o_status;
    logic        o_need_more, o_data_valid, o_frame_end, o_message_end;
    logic [7:0]  o_data_out;
    logic        o_reply_valid, o_reply_last, o_reply_ram;
    logic [7:0]  o_reply_byte;

    logic                        proc;
    logic                        ram_we, ram_re;
    logic [wsd_pkg::RAM_AW-1:0]  ram_waddr, ram_raddr;
    logic [7:0]                  ram_wdata, ram_rdata;

    assign q_ready = !out_valid_reg || out_ready;
    assign proc    = q_valid && q_ready;

    always_comb
    begin
        logic [7:0]  b;
        logic [3:0]  pos;
        logic [3:0]  eb;
        logic [3:0]  m;
        logic [63:0] len;
        logic        fail;
        logic        done;
        logic        masked;
        logic [7:0]  v;
        logic [6:0]  n;
        logic [7:0]  tk;

        b    = q_item.data_byte;
        pos  = hcount_reg;
        eb   = 4'd0;
        m    = 4'd0;
        len  = 64'd0;
        fail = 1'b0;
        done = 1'b0;
        masked = b[7];
        v    = 8'd0;
        n    = 7'd0;
        tk   = rtaken_reg + 8'd1;

        stage_next     = stage_reg;
        hcount_next    = hcount_reg;
        hneed_next     = hneed_reg;
        first_next     = first_reg;
        lcode_next     = lcode_reg;
        ext_next       = ext_reg;
        opcode_next    = opcode_reg;
        ctrl_next      = ctrl_reg;
        msg_open_next  = msg_open_reg;
        remain_next    = remain_reg;
        key_next       = key_reg;
        kidx_next      = kidx_reg;
        ccount_next    = ccount_reg;
        ctrl_bank_next = ctrl_bank_reg;
        reply_bank_next = reply_bank_reg;
        rlen_next      = rlen_reg;
        rtaken_next    = rtaken_reg;
        rhdr_next      = rhdr_reg;

        o_status      = wsd_pkg::STATUS_OK;
        o_need_more   = 1'b0;
        o_data_valid  = 1'b0;
        o_data_out    = 8'd0;
        o_frame_end   = 1'b0;
        o_message_end = 1'b0;
        o_reply_valid = 1'b0;
        o_reply_byte  = 8'd0;
        o_reply_last  = 1'b0;
        o_reply_ram   = 1'b0;

        ram_we    = 1'b0;
        ram_wdata = 8'd0;
        ram_waddr = {ctrl_bank_reg, ccount_reg[wsd_pkg::BANK_AW-1:0]};
        ram_re    = 1'b0;
        ram_raddr = {reply_bank_reg, 7'(rtaken_reg - 8'd2)};

        if (q_item.operation == wsd_pkg::OPERATION_DRAIN)
        begin
            if (rtaken_reg < rlen_reg)
            begin
                o_reply_valid = 1'b1;
                rtaken_next   = tk;
                o_reply_last  = (tk == rlen_reg);
                if (rtaken_reg == 8'd0)
                begin
                    o_reply_byte = rhdr_reg;
                end
                else if (rtaken_reg == 8'd1)
                begin
                    o_reply_byte = rlen_reg - 8'd2;
                end
                else
                begin
                    o_reply_ram = 1'b1;
                    ram_re      = proc;
                end
            end
            else
            begin
                o_status = wsd_pkg::STATUS_NO_REPLY;
            end
        end
        else if (stage_reg == wsd_pkg::ST_ERROR)
        begin
            o_status = wsd_pkg::STATUS_PROTOCOL;
        end
        else if (stage_reg != wsd_pkg::ST_OPEN)
        begin
            o_status = wsd_pkg::STATUS_CLOSED;
        end
        else
        begin
            if (remain_reg == 64'd0)
            begin
                if (pos >= 4'(wsd_pkg::HEADER_MAX))
                begin
                    fail = 1'b1;
                end
                else
                begin
                    hcount_next = pos + 4'd1;
                    if (pos == 4'd0)
                    begin
                        first_next = b;
                    end
                    else if (pos == 4'd1)
                    begin
                        lcode_next  = b[6:0];
                        hneed_next  = 4'd2 + (masked ? 4'd4 : 4'd0)
                                      + wsd_pkg::ext_bytes(b[6:0]);
                        opcode_next = first_reg[3:0];
                        ctrl_next   = first_reg[3];
                        ext_next    = 64'd0;
                        for (int i = 0; i < 4; i++) key_next[i] = 8'd0;
                        if ((first_reg[6:4] != 3'd0) || (masked != expect_masked_reg))
                        begin
                            fail = 1'b1;
                        end
                        else if (first_reg[3])
                        begin
                            if (!first_reg[7] || b[6:0] > 7'd125)
                            begin
                                fail = 1'b1;
                            end
                            else if (first_reg[3:0] != wsd_pkg::OP_CLOSE
                                     && first_reg[3:0] != wsd_pkg::OP_PING
                                     && first_reg[3:0] != wsd_pkg::OP_PONG)
                            begin
                                fail = 1'b1;
                            end
                        end
                        else if (first_reg[3:0] != wsd_pkg::OP_BINARY
                                 && first_reg[3:0] != wsd_pkg::OP_CONT)
                        begin
                            fail = 1'b1;
                        end
                    end
                    else
                    begin
                        eb = wsd_pkg::ext_bytes(lcode_reg);
                        if (pos < 4'd2 + eb)
                        begin
                            ext_next = {ext_reg[55:0], b};
                        end
                        else
                        begin
                            m = pos - 4'd2 - eb;
                            if (m < 4'd4) key_next[m[1:0]] = b;
                        end
                    end

                    // Header completion
                    if (!fail && hneed_next != 4'd0 && hcount_next == hneed_next)
                    begin
                        if (lcode_next == 7'd126)
                        begin
                            len = {48'd0, ext_next[15:0]};
                            if (len < 64'd126) fail = 1'b1;
                        end
                        else if (lcode_next == 7'd127)
                        begin
                            len = ext_next;
                            if (len <= 64'hffff || len[63]) fail = 1'b1;
                        end
                        else
                        begin
                            len = {57'd0, lcode_next};
                        end
                        if (!expect_masked_reg)
                        begin
                            for (int i = 0; i < 4; i++) key_next[i] = 8'd0;
                        end
                        kidx_next   = 2'd0;
                        ccount_next = 7'd0;
                        if (!ctrl_next)
                        begin
                            if (opcode_next == wsd_pkg::OP_CONT && !msg_open_reg)
                            begin
                                fail = 1'b1;
                            end
                            if (opcode_next == wsd_pkg::OP_BINARY && msg_open_reg)
                            begin
                                fail = 1'b1;
                            end
                            msg_open_next = !first_next[7];
                        end
                        remain_next = len;
                        done = (len == 64'd0);
                    end
                end
            end
            else
            begin
                v         = b ^ key_reg[kidx_reg];
                kidx_next = kidx_reg + 2'd1;
                if (ctrl_reg)
                begin
                    if (ccount_reg >= 7'(wsd_pkg::CONTROL_MAX))
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        ram_we      = proc;
                        ram_wdata   = v;
                        ccount_next = ccount_reg + 7'd1;
                    end
                end
                else
                begin
                    o_data_valid = 1'b1;
                    o_data_out   = v;
                end
                remain_next = remain_reg - 64'd1;
                done = (remain_next == 64'd0);
            end

            if (fail)
            begin
                stage_next   = wsd_pkg::ST_ERROR;
                o_status     = wsd_pkg::STATUS_PROTOCOL;
                o_data_valid = 1'b0;
                o_data_out   = 8'd0;
            end
            else
            begin
                o_need_more = q_item.chunk_end;
                if (done)
                begin
                    hcount_next = 4'd0;
                    hneed_next  = 4'd0;
                    if (ctrl_next)
                    begin
                        if (opcode_next == wsd_pkg::OP_CLOSE)
                        begin
                            n = (ccount_next >= 7'd2) ? 7'd2 : 7'd0;
                        end
                        else
                        begin
                            n = ccount_next;
                        end
                        // A new reply swaps the stored payload bank into the reply side.
                        if ((opcode_next == wsd_pkg::OP_PING
                             || opcode_next == wsd_pkg::OP_CLOSE)
                            && rlen_reg == rtaken_reg)
                        begin
                            rhdr_next       = (opcode_next == wsd_pkg::OP_PING)
                                              ? {4'h8, wsd_pkg::OP_PONG}
                                              : {4'h8, wsd_pkg::OP_CLOSE};
                            rlen_next       = 8'd2 + {1'b0, n};
                            rtaken_next     = 8'd0;
                            reply_bank_next = ctrl_bank_reg;
                            ctrl_bank_next  = reply_bank_reg;
                        end
                        if (opcode_next == wsd_pkg::OP_CLOSE)
                        begin
                            stage_next  = wsd_pkg::ST_CLOSED;
                            o_status    = wsd_pkg::STATUS_CLOSED;
                            o_need_more = 1'b0;
                        end
                        else
                        begin
                            ccount_next = 7'd0;
                        end
                    end
                    else
                    begin
                        o_frame_end   = 1'b1;
                        o_message_end = first_next[7];
                        ccount_next   = 7'd0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_masked_reg <= 1'b1;
            stage_reg      <= wsd_pkg::ST_OPEN;
            hcount_reg     <= 4'd0;
            hneed_reg      <= 4'd0;
            first_reg      <= 8'd0;
            lcode_reg      <= 7'd0;
            ext_reg        <= 64'd0;
            opcode_reg     <= 4'd0;
            ctrl_reg       <= 1'b0;
            msg_open_reg   <= 1'b0;
            remain_reg     <= 64'd0;
            for (int i = 0; i < 4; i++) key_reg[i] <= 8'd0;
            kidx_reg       <= 2'd0;
            ccount_reg     <= 7'd0;
            ctrl_bank_reg  <= 1'b0;
            reply_bank_reg <= 1'b1;
            rlen_reg       <= 8'd0;
            rtaken_reg     <= 8'd0;
            rhdr_reg       <= 8'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                expect_masked_reg <= cfg_wdata;
            end
            if (proc)
            begin
                stage_reg      <= stage_next;
                hcount_reg     <= hcount_next;
                hneed_reg      <= hneed_next;
                first_reg      <= first_next;
                lcode_reg      <= lcode_next;
                ext_reg        <= ext_next;
                opcode_reg     <= opcode_next;
                ctrl_reg       <= ctrl_next;
                msg_open_reg   <= msg_open_next;
                remain_reg     <= remain_next;
                key_reg        <= key_next;
                kidx_reg       <= kidx_next;
                ccount_reg     <= ccount_next;
                ctrl_bank_reg  <= ctrl_bank_next;
                reply_bank_reg <= reply_bank_next;
                rlen_reg       <= rlen_next;
                rtaken_reg     <= rtaken_next;
                rhdr_reg       <= rhdr_next;
            end
            if (proc)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            status_reg      <= o_status;
            need_more_reg   <= o_need_more;
            data_valid_reg  <= o_data_valid;
            data_out_reg    <= o_data_out;
            frame_end_reg   <= o_frame_end;
            message_end_reg <= o_message_end;
            reply_valid_reg <= o_reply_valid;
            reply_byte_reg  <= o_reply_byte;
            reply_last_reg  <= o_reply_last;
            reply_ram_reg   <= o_reply_ram;
        end
    end

    wsd_ram #(
        .WIDTH (8),
        .DEPTH (wsd_pkg::RAM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign need_more   = need_more_reg;
    assign data_valid  = data_valid_reg;
    assign data_out    = data_out_reg;
    assign frame_end   = frame_end_reg;
    assign message_end = message_end_reg;
    assign reply_valid = reply_valid_reg;
    assign reply_byte  = reply_ram_reg ? ram_rdata : reply_byte_reg;
    assign reply_last  = reply_last_reg;

`ifndef SYNTHESIS
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stage_reg == wsd_pkg::ST_ERROR |=> stage_reg == wsd_pkg::ST_ERROR)
        else $error("error stage left");
    a_banks_apart: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_bank_reg != reply_bank_reg) else $error("payload banks collide");
    a_taken_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rtaken_reg <= rlen_reg) else $error("reply drained past its end");
    a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && data_valid_reg) |-> status_reg == wsd_pkg::STATUS_OK)
        else $error("data byte with bad status");
`endif

endmodule

FILE: sv/websocket_frame_deframer_core.sv
// An accepted transaction passes the front queue, then the parser and its output register.
// Throughput: one transaction per cycle unless out_ready stalls the output register.
// Reply bytes beyond the two header bytes come from a registered-read RAM port.
// Reset (rst_n, asynchronous, active low) opens the connection, clears the
// parser state and sets expect_masked to 1; the payload RAM is not cleared.
module websocket_frame_deframer_core (
    input  logic       clk,
    input  logic       rst_n,
    // Configuration: single register, written whenever cfg_we is high.
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    // Input channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       operation,
    input  logic [7:0] data_byte,
    input  logic       chunk_end,
    // Result channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic       need_more,
    output logic       data_valid,
    output logic [7:0] data_out,
    output logic       frame_end,
    output logic       message_end,
    output logic       reply_valid,
    output logic [7:0] reply_byte,
    output logic       reply_last
);

    wsd_pkg::item_t in_item;
    wsd_pkg::item_t q_item;
    logic           q_valid;
    logic           q_ready;

    assign in_item.operation = operation;
    assign in_item.data_byte = data_byte;
    assign in_item.chunk_end = chunk_end;

    // The two-entry front queue absorbs stalls on the result side so the link side
    // keeps moving, until the queue fills, while a finished result waits to be taken.
    wsd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    // The back end parses headers, unmasks payload, keeps control payloads
    // in one RAM bank and swaps that bank to the reply side when a pong or
    // close echo is queued, so no copy of the payload is ever made.
    wsd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .need_more   (need_more),
        .data_valid  (data_valid),
        .data_out    (data_out),
        .frame_end   (frame_end),
        .message_end (message_end),
        .reply_valid (reply_valid),
        .reply_byte  (reply_byte),
        .reply_last  (reply_last)
    );

endmodule
